// ----- rtl/tbrl_pkg.sv -----
// Shared types and constants for the token bucket rate limiter.
package tbrl_pkg;

  localparam int unsigned TOK_W     = 32;  // token count, capacity, rate
  localparam int unsigned WAIT_W    = 32;  // wait result in milliseconds
  localparam int unsigned CNT_W     = 5;   // step counter of the shared unit
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TOK_W-1:0] US_PER_S   = 32'd1000000;
  localparam logic [TOK_W-1:0] MS_PER_S   = 32'd1000;
  localparam logic [TOK_W-1:0] CAP_RESET  = 32'd65536;
  localparam logic [TOK_W-1:0] RATE_RESET = 32'd1048576;
  localparam logic [WAIT_W-1:0] WAIT_SAT  = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd1;

  localparam logic CMD_TAKE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REFILL,
    ST_MUL,
    ST_ADD,
    ST_PRE,
    ST_DIV,
    ST_APPLY,
    ST_DECIDE,
    ST_QEND,
    ST_DONE
  } tbrl_state_e;

endpackage

// ----- rtl/token_bucket_rate_limiter_core.sv -----
// Byte token bucket rate limiter: sequencer around one shift-add / divide unit.
//
// Usage: one beat on s_axis carries a request: tuser is the command (take or
// wait query), tdata holds byte_count and the microsecond timestamp. Each
// request yields exactly one beat on m_axis: tuser is granted, tdata holds
// wait_ms and tokens_left. capacity and rate are written over the cfg port
// while the block is idle; writing capacity fills the bucket and restarts time.
//
// Flow: refill and wait-time work runs through one shared unit that does 32
// shift-add steps to form a product and 32 restoring-divide steps to scale it. A
// take, or a query, whose refill runs the product goes on to the divide, which is
// skipped when the gain saturates; a wait time adds a second product and divide
// (deficit times 1000 plus rounding, divided by rate). Items with no refill work
// (first timestamp, time not advancing) go straight to the decision, a query at
// zero rate to the result. s_axis_tready is high only while the sequencer is
// idle; a new beat can be accepted in the cycle in which the result appears.
//
// Reset: capacity 65536, rate 1048576, bucket full, clock not started.
// If m_axis stalls, one more request is taken and worked; its result then
// holds the sequencer, which accepts nothing until the output register frees.
module token_bucket_rate_limiter_core #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned BYTE_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [tbrl_pkg::TOK_W-1:0]             cfg_wdata_i,
  // request stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: byte_count, timestamp (from bit 0 up), zero padded to whole bytes
  input  logic [((BYTE_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: command
  input  logic                                   s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: wait_ms, tokens_left (from bit 0 up)
  output logic [63:0]                            m_axis_tdata,
  // tuser: granted
  output logic                                   m_axis_tuser
);
  import tbrl_pkg::*;

  localparam int unsigned OW = (TIME_BITS > BYTE_BITS) ? TIME_BITS : BYTE_BITS;
  localparam int unsigned CW = (BYTE_BITS > TOK_W) ? BYTE_BITS : TOK_W;
  localparam int unsigned AW = OW + 33;

  tbrl_state_e state_q, state_d;

  logic                 cmd_q, cmd_d;
  logic [BYTE_BITS-1:0] bytes_q, bytes_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TOK_W-1:0]     cap_q, cap_d;
  logic [TOK_W-1:0]     rate_q, rate_d;
  logic [TOK_W-1:0]     tok_q, tok_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic [OW-1:0]        mcand_q, mcand_d;
  logic [TOK_W-1:0]     mul_q, mul_d;
  logic [AW-1:0]        acc_q, acc_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 mode_q, mode_d;   // 0: refill scaling, 1: wait time
  logic                 sat_q, sat_d;
  logic                 grant_q, grant_d;
  logic [WAIT_W-1:0]    wait_q, wait_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_grant_q, out_grant_d;
  logic [WAIT_W-1:0]    out_wait_q, out_wait_d;
  logic [TOK_W-1:0]     out_tok_q, out_tok_d;

  // shared unit
  logic [AW-1:0]        add_base, add_opnd, add_sum;
  logic [TOK_W-1:0]     div_den;
  logic [TOK_W:0]       div_t, div_r;
  logic                 div_ge, pre_ge;
  logic [TOK_W-1:0]     div_rem;

  logic [TIME_BITS-1:0] elapsed;
  logic [CW-1:0]        tok_x, bytes_x;
  logic [TOK_W-1:0]     add_val, room;
  logic                 in_fire, out_free;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign add_base = (state_q == ST_MUL) ? (acc_q << 1) : acc_q;
  always_comb begin
    if (state_q == ST_MUL) begin
      add_opnd = mul_q[TOK_W-1] ? AW'(mcand_q) : '0;
    end else begin
      add_opnd = AW'(rate_q - 32'd1);
    end
  end
  assign add_sum = add_base + add_opnd;

  assign div_den = mode_q ? rate_q : US_PER_S;
  assign pre_ge  = acc_q[AW-1:TOK_W] >= (AW-TOK_W)'(div_den);
  assign div_t   = {acc_q[2*TOK_W-1:TOK_W], acc_q[TOK_W-1]};
  assign div_r   = div_t - {1'b0, div_den};
  assign div_ge  = div_t >= {1'b0, div_den};
  assign div_rem = div_ge ? div_r[TOK_W-1:0] : div_t[TOK_W-1:0];

  assign elapsed = now_q - last_q;
  assign tok_x   = CW'(tok_q);
  assign bytes_x = CW'(bytes_q);
  assign add_val = acc_q[TOK_W-1:0];
  assign room    = (cap_q > tok_q) ? (cap_q - tok_q) : '0;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    bytes_d     = bytes_q;
    now_d       = now_q;
    cap_d       = cap_q;
    rate_d      = rate_q;
    tok_d       = tok_q;
    last_d      = last_q;
    mcand_d     = mcand_q;
    mul_d       = mul_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    sat_d       = sat_q;
    grant_d     = grant_q;
    wait_d      = wait_q;
    out_valid_d = out_valid_q;
    out_grant_d = out_grant_q;
    out_wait_d  = out_wait_q;
    out_tok_d   = out_tok_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d   = s_axis_tuser;
          bytes_d = s_axis_tdata[BYTE_BITS-1:0];
          now_d   = s_axis_tdata[BYTE_BITS+TIME_BITS-1:BYTE_BITS];
          grant_d = 1'b0;
          wait_d  = '0;
          if (s_axis_tuser == CMD_QUERY && rate_q == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_REFILL;
          end
        end
      end
      ST_REFILL: begin
        mode_d = 1'b0;
        if (last_q == '0) begin
          last_d  = now_q;
          state_d = ST_DECIDE;
        end else if (now_q <= last_q) begin
          state_d = ST_DECIDE;
        end else begin
          mcand_d = OW'(elapsed);
          mul_d   = rate_q;
          acc_d   = '0;
          cnt_d   = '1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_d = add_sum;
        mul_d = mul_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = mode_q ? ST_ADD : ST_PRE;
        end
      end
      ST_ADD: begin
        // round up: numerator plus rate minus one
        acc_d   = add_sum;
        state_d = ST_PRE;
      end
      ST_PRE: begin
        // quotient of 2^32 or more saturates; else the top word is the remainder
        sat_d = pre_ge;
        cnt_d = '1;
        if (pre_ge) begin
          state_d = mode_q ? ST_QEND : ST_APPLY;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        acc_d = '0;
        acc_d[2*TOK_W-1:0] = {div_rem, acc_q[TOK_W-2:0], div_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = mode_q ? ST_QEND : ST_APPLY;
        end
      end
      ST_APPLY: begin
        // keep last time when nothing was added so fractional credit survives
        if (sat_q || add_val != '0) begin
          if (tok_q >= cap_q || sat_q || add_val >= room) begin
            tok_d = cap_q;
          end else begin
            tok_d = tok_q + add_val;
          end
          last_d = now_q;
        end
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (cmd_q == CMD_TAKE) begin
          if (tok_x >= bytes_x) begin
            tok_d   = tok_q - bytes_x[TOK_W-1:0];
            grant_d = 1'b1;
          end
          state_d = ST_DONE;
        end else if (tok_x < bytes_x) begin
          mcand_d = OW'(bytes_x - tok_x);
          mul_d   = MS_PER_S;
          acc_d   = '0;
          cnt_d   = '1;
          mode_d  = 1'b1;
          state_d = ST_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_QEND: begin
        wait_d  = sat_q ? WAIT_SAT : acc_q[WAIT_W-1:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_grant_d = grant_q;
          out_wait_d  = wait_q;
          out_tok_d   = tok_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAPACITY: begin
          cap_d  = cfg_wdata_i;
          tok_d  = cfg_wdata_i;
          last_d = '0;
        end
        REG_RATE: begin
          rate_d = cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      rate_q      <= RATE_RESET;
      tok_q       <= CAP_RESET;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      rate_q      <= rate_d;
      tok_q       <= tok_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    bytes_q     <= bytes_d;
    now_q       <= now_d;
    mcand_q     <= mcand_d;
    mul_q       <= mul_d;
    acc_q       <= acc_d;
    cnt_q       <= cnt_d;
    mode_q      <= mode_d;
    sat_q       <= sat_d;
    grant_q     <= grant_d;
    wait_q      <= wait_d;
    out_grant_q <= out_grant_d;
    out_wait_q  <= out_wait_d;
    out_tok_q   <= out_tok_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_tok_q, out_wait_q};
  assign m_axis_tuser  = out_grant_q;

endmodule

// ----- rtl/tbrl_checker.sv -----
// Port-level checks for the token bucket rate limiter, bound to the top level.
module tbrl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import tbrl_pkg::*;

  // one item in flight: accepting a beat closes the input side
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous item still in work");

  // a new result appears only after the sequencer was busy
  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a request in work");

  // a granted take never reports a wait time
  a_grant_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[WAIT_W-1:0] == '0))
    else $error("granted beat carries nonzero wait");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result beat changed");

endmodule

bind token_bucket_rate_limiter_core tbrl_checker u_tbrl_checker (.*);

// ----- tb/sv/tb_token_bucket_rate_limiter_core.sv -----
// Self-checking testbench for the token bucket core: directed and random beats, scoreboard.
`timescale 1ns / 100ps

module tb_token_bucket_rate_limiter_core;
  import tbrl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int unsigned          PHASES       = 8;
  localparam int unsigned          PHASE_ITEMS  = 225;

  typedef struct packed {
    logic              granted;
    logic [WAIT_W-1:0] wait_ms;
    logic [TOK_W-1:0]  tokens_left;
  } bucket_result_t;

  class bucket_scoreboard;
    logic [TOK_W-1:0] capacity;
    logic [TOK_W-1:0] rate;
    logic [TOK_W-1:0] tokens;
    logic [47:0]      fill_stamp_us;
    bucket_result_t   expected_results[$];
    int               errors;

    function new();
      capacity      = CAP_RESET;
      rate          = RATE_RESET;
      tokens        = CAP_RESET;
      fill_stamp_us = '0;
      errors        = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [TOK_W-1:0] value);
      if (idx == REG_CAPACITY) begin
        capacity      = value;
        tokens        = value;
        fill_stamp_us = '0;
      end else if (idx == REG_RATE) begin
        rate = value;
      end
    endfunction

    function void note_request(logic cmd, logic [TOK_W-1:0] bytes, logic [47:0] now_us);
      logic [127:0]     gain;
      logic [TOK_W-1:0] room;
      logic [63:0]      deficit;
      logic [63:0]      ms;
      bucket_result_t   res;
      res = '0;
      // a query at zero rate skips the refill
      if (cmd == CMD_TAKE || rate != 0) begin
        if (fill_stamp_us == 0) begin
          fill_stamp_us = now_us;
        end else if (now_us > fill_stamp_us) begin
          gain = (128'(rate) * 128'(now_us - fill_stamp_us)) / 128'(US_PER_S);
          // hold the refill time on a zero gain so fractional credit carries over
          if (gain != 0) begin
            room = (tokens < capacity) ? capacity - tokens : '0;
            if (gain >= 128'(room)) tokens = capacity;
            else tokens = tokens + gain[TOK_W-1:0];
            fill_stamp_us = now_us;
          end
        end
      end
      if (cmd == CMD_TAKE) begin
        if (tokens >= bytes) begin
          tokens      = tokens - bytes;
          res.granted = 1'b1;
        end
      end else if (rate != 0 && tokens < bytes) begin
        deficit     = 64'(bytes - tokens);
        ms          = (deficit * 64'(MS_PER_S) + 64'(rate) - 64'd1) / 64'(rate);
        res.wait_ms = (ms > 64'(WAIT_SAT)) ? WAIT_SAT : ms[WAIT_W-1:0];
      end
      res.tokens_left = tokens;
      expected_results.push_back(res);
    endfunction

    function void check_result(bucket_result_t got);
      bucket_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no request pending: %h", got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.granted !== want.granted) begin
          $error("granted: expected %0d, actual %0d", want.granted, got.granted);
          errors++;
        end
        if (got.wait_ms !== want.wait_ms) begin
          $error("wait_ms: expected %0d, actual %0d", want.wait_ms, got.wait_ms);
          errors++;
        end
        if (got.tokens_left !== want.tokens_left) begin
          $error("tokens_left: expected %0d, actual %0d", want.tokens_left, got.tokens_left);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [TOK_W-1:0]     cfg_wdata = '0;
  logic                 s_valid   = 1'b0;
  logic [79:0]          s_data    = '0;  // byte_count, timestamp
  logic                 s_user    = 1'b0;  // command
  logic                 m_ready   = 1'b0;
  logic                 s_ready;
  logic                 m_valid;
  logic [63:0]          m_data;  // wait_ms, tokens_left
  logic                 m_user;  // granted

  bucket_scoreboard sb;
  bit               steady = 1'b0;
  logic [47:0]      now_us = '0;

  token_bucket_rate_limiter_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check each beat, stall at random, one long hold-off
  int             result_beats  = 0;
  int             hold_cycles   = 0;
  bit             long_hold_done = 1'b0;
  bucket_result_t seen;

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      seen.granted     = m_user;
      seen.wait_ms     = m_data[31:0];
      seen.tokens_left = m_data[63:32];
      sb.check_result(seen);
      result_beats++;
    end
    if (!long_hold_done && result_beats == 350) begin
      hold_cycles    = 600;
      long_hold_done = 1'b1;
    end else if (hold_cycles == 0 && !steady && $urandom_range(0, 299) == 0) begin
      hold_cycles = $urandom_range(10, 120);
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= steady || ($urandom_range(0, 99) >= 33);
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [TOK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    sb.note_config(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // leaves tvalid high after the accepting edge; a drain or a gap in the next call lowers it
  task automatic offer_request(logic cmd, logic [TOK_W-1:0] bytes, logic [47:0] ts);
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      if ($urandom_range(0, 99) < 33) gap = $urandom_range(1, 4);
      else if ($urandom_range(0, 49) == 0) gap = $urandom_range(20, 160);
    end
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {ts, bytes};
    @(posedge clk_i);
    while (s_ready !== 1'b1) @(posedge clk_i);
    sb.note_request(cmd, bytes, ts);
  endtask

  task automatic run_directed();
    // reset settings: not started, time standing still, going backwards, huge jump
    offer_request(CMD_TAKE, 32'd0, 48'd0);
    offer_request(CMD_TAKE, 32'hFFFF_FFFF, 48'd0);
    offer_request(CMD_QUERY, 32'hFFFF_FFFF, 48'd0);
    offer_request(CMD_TAKE, 32'd1000, 48'd1000);
    offer_request(CMD_TAKE, 32'd100, 48'd1001);
    offer_request(CMD_QUERY, 32'd64536, 48'd1001);
    offer_request(CMD_TAKE, 32'd5, 48'd500);
    offer_request(CMD_QUERY, 32'd10, 48'd2000);
    offer_request(CMD_TAKE, 32'd65536, 48'd2000);
    offer_request(CMD_TAKE, 32'd0, 48'hFFFF_FFFF_FFFF);
    offer_request(CMD_QUERY, 32'd0, 48'hFFFF_FFFF_FFFF);
    wait_drained();
    // everything at maximum: exact product far beyond 64 bits
    write_register(REG_CAPACITY, 32'hFFFF_FFFF);
    write_register(REG_RATE, 32'hFFFF_FFFF);
    offer_request(CMD_TAKE, 32'hFFFF_FFFF, 48'd1);
    offer_request(CMD_QUERY, 32'hFFFF_FFFF, 48'd1);
    offer_request(CMD_TAKE, 32'd0, 48'hFFFF_FFFF_FFFF);
    wait_drained();
    // slowest rate: zero gains keep the refill time, wait saturates
    write_register(REG_CAPACITY, 32'd1000);
    write_register(REG_RATE, 32'd1);
    offer_request(CMD_TAKE, 32'd1000, 48'd10);
    offer_request(CMD_TAKE, 32'd0, 48'd500000);
    offer_request(CMD_TAKE, 32'd1, 48'd1000010);
    offer_request(CMD_QUERY, 32'hFFFF_FFFF, 48'd1000010);
    wait_drained();
    // zero rate and zero capacity; spare indexes change nothing
    write_register(REG_RATE, 32'd0);
    write_register(REG_CAPACITY, 32'd0);
    write_register(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_register(REG_SPARE_HI, 32'h1234_5678);
    offer_request(CMD_QUERY, 32'd5, 48'd7);
    offer_request(CMD_TAKE, 32'd0, 48'd7);
    offer_request(CMD_TAKE, 32'd1, 48'd99999999);
    offer_request(CMD_QUERY, 32'd0, 48'd99999999);
    wait_drained();
  endtask

  task automatic run_random_phase(int unsigned items);
    int unsigned r;
    logic [63:0] wide;
    logic [47:0] ts;
    logic [31:0] bytes;
    logic        cmd;
    for (int unsigned i = 0; i < items; i++) begin
      // pause the sender once per phase until the bucket is quiet
      if (i == items / 2) wait_drained();
      wide = {$urandom(), $urandom()};
      r    = $urandom_range(0, 99);
      if (r < 2) begin
        ts = '0;
      end else if (r < 5) begin
        ts     = wide[47:0];
        now_us = ts;
      end else if (r < 10) begin
        ts = now_us - 48'($urandom_range(0, 2000));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: now_us = now_us + 48'($urandom_range(0, 100));
          4, 5, 6:    now_us = now_us + 48'($urandom_range(0, 20000));
          7, 8:       now_us = now_us + 48'($urandom_range(0, 2000000));
          default:    now_us = now_us + 48'($urandom());
        endcase
        ts = now_us;
      end
      r = $urandom_range(0, 99);
      if (r < 4) bytes = '0;
      else if (r < 7) bytes = 32'hFFFF_FFFF;
      else if (r < 15) bytes = $urandom();
      else bytes = $urandom_range(0, sb.capacity / 3 + 2);
      cmd = ($urandom_range(0, 1) == 0) ? CMD_TAKE : CMD_QUERY;
      offer_request(cmd, bytes, ts);
    end
  endtask

  initial begin
    logic [TOK_W-1:0] cap;
    logic [TOK_W-1:0] rate;
    logic [63:0]      wide;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int unsigned p = 0; p < PHASES; p++) begin
      wait_drained();
      steady = (p == 3);
      wide   = {$urandom(), $urandom()};
      if (p == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       cap = '0;
          1:       cap = $urandom_range(1, 255);
          2:       cap = CAP_RESET;
          3:       cap = $urandom_range(1, 1 << 20);
          4:       cap = $urandom();
          default: cap = 32'hFFFF_FFFF;
        endcase
        write_register(REG_CAPACITY, cap);
        now_us = ($urandom_range(0, 3) == 0) ? wide[47:0] : 48'($urandom_range(1, 1000000));
      end
      case ($urandom_range(0, 5))
        0:       rate = '0;
        1:       rate = 32'd1;
        2:       rate = $urandom_range(1, 1000);
        3:       rate = $urandom_range(1000, 1 << 21);
        4:       rate = $urandom();
        default: rate = 32'hFFFF_FFFF;
      endcase
      write_register(REG_RATE, rate);
      if ($urandom_range(0, 3) == 0) begin
        write_register(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
      end
      run_random_phase(PHASE_ITEMS);
    end
    steady = 1'b0;
    wait_drained();
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
